### hdl/prime_modular_alu_macros.svh
// assertion helpers for the modular alu
`ifndef PRIME_MODULAR_ALU_MACROS_SVH
`define PRIME_MODULAR_ALU_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pma_pkg.sv
package pma_pkg;

  // operation selector codes
  typedef enum logic [3:0] {
    FN_REDUCE = 4'd0,
    FN_NEGATE = 4'd1,
    FN_ADD    = 4'd2,
    FN_SUB    = 4'd3,
    FN_MUL    = 4'd4,
    FN_DIV    = 4'd5,
    FN_POW    = 4'd6,
    FN_INV    = 4'd7,
    FN_EQUAL  = 4'd8
  } func_t;

  // sequencer states
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_RED   = 10'b0000000010,
    ST_RFIX  = 10'b0000000100,
    ST_DISP  = 10'b0000001000,
    ST_FIN   = 10'b0000010000,
    ST_PSTEP = 10'b0000100000,
    ST_MUL   = 10'b0001000000,
    ST_MEND  = 10'b0010000000,
    ST_PEND  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  // where a finished modular product goes
  typedef enum logic [1:0] {
    TGT_RES  = 2'd0,
    TGT_PACC = 2'd1,
    TGT_PSQ  = 2'd2
  } tgt_t;

  localparam logic [30:0] MODULUS_RESET = 31'd998244353;
  // last step index of an operand reduction and of a modular product
  localparam logic [5:0]  RED_LAST = 6'd63;
  localparam logic [5:0]  MUL_LAST = 6'd30;

endpackage

### hdl/prime_modular_alu.sv
// Modular arithmetic unit over a prime modulus M (31 bits, reset 998244353) set through
// the cfg port while the block is idle. Each input word selects reduce, negate, add,
// subtract, multiply, divide, power, inverse or equality test on two signed 64-bit
// operands and yields one 31-bit residue. Reductions, adds and products go through one shared
// double-add-reduce step unit (a 33-bit add and a compare against M and 2M) under a
// one-hot sequencer, and the block takes no new word until the current one is in the
// output register. Each operand reduction runs one bit per cycle over 64 bits, and every
// word reduces both operands, fixes them up and dispatches; reduce, negate and equal then
// finish directly, add and subtract after one more step unit pass, multiply after one product.
// Power and inverse run square-and-multiply with a bit-serial modular product per step:
// one square per exponent bit up to the highest set bit plus one multiply per set bit;
// divide adds one product after the inverse. A modulus of zero returns 0 right away.
// The cfg port is ready only while the block is idle with no result pending and no input
// word offered.
`include "prime_modular_alu_macros.svh"

module prime_modular_alu #(
  parameter int EXP_BITS = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  // operation words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_func,
  input  logic signed [63:0] in_operand_a,
  input  logic signed [63:0] in_operand_b,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic [30:0]        out_result_value,
  // modulus register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_modulus
);

  pma_pkg::state_t state_r, state_nxt;
  logic [30:0]     m_r, m_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [30:0]     res_r, res_nxt;

  pma_pkg::func_t  func_r, func_nxt;
  pma_pkg::tgt_t   tgt_r, tgt_nxt;
  logic [63:0]     raw_r, raw_nxt;     // operand magnitude, shifted out msb first
  logic [63:0]     opb_r, opb_nxt;     // raw operand b, also the power exponent
  logic            flip_r, flip_nxt;   // negate the residue after reduction
  logic            sel_b_r, sel_b_nxt; // reducing operand b
  logic [30:0]     a_r, a_nxt;
  logic [30:0]     b_r, b_nxt;
  logic [30:0]     acc_r, acc_nxt;     // step unit accumulator
  logic [5:0]      cnt_r, cnt_nxt;
  logic [30:0]     x_r, x_nxt;         // multiplicand
  logic [30:0]     y_r, y_nxt;         // multiplier, shifted out msb first
  logic [30:0]     pacc_r, pacc_nxt;   // power accumulator
  logic [30:0]     psq_r, psq_nxt;     // running square
  logic [EXP_BITS-1:0] exp_r, exp_nxt;
  logic [30:0]     val_r, val_nxt;     // finished residue waiting for the output register

  // shared step unit: t = (2*acc or acc) + addend, then subtract 0, M or 2M
  logic        unit_dbl;
  logic [30:0] unit_acc;
  logic [30:0] unit_add;
  logic [32:0] unit_t;
  logic [32:0] unit_m1;
  logic [32:0] unit_m2;
  logic [32:0] unit_d;
  logic [30:0] unit_q;

  // operand loader: magnitude of a signed 64-bit operand
  logic [63:0] ld_src;
  logic [63:0] ld_mag;

  logic [63:0] m_less2;   // inverse exponent
  logic [30:0] unit_one;  // 1 mod M
  logic [30:0] fix_val;   // reduced residue with sign applied

  assign in_stall         = (state_r != pma_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = res_r;
  assign cfg_ready        = (state_r == pma_pkg::ST_IDLE) && !out_valid_r && !in_valid;

  assign ld_src   = (state_r == pma_pkg::ST_IDLE) ? $unsigned(in_operand_a) : opb_r;
  assign ld_mag   = ld_src[63] ? (64'd0 - ld_src) : ld_src;
  assign m_less2  = {33'd0, m_r} - 64'd2;
  assign unit_one = (m_r == 31'd1) ? 31'd0 : 31'd1;
  assign fix_val  = (flip_r && (acc_r != 31'd0)) ? (m_r - acc_r) : acc_r;

  // unit operand selection
  always_comb begin
    unit_dbl = 1'b1;
    unit_acc = acc_r;
    unit_add = 31'd0;
    case (state_r)
      pma_pkg::ST_RED: begin
        unit_add = {30'd0, raw_r[63]};
      end
      pma_pkg::ST_MUL: begin
        unit_add = y_r[30] ? x_r : 31'd0;
      end
      pma_pkg::ST_FIN: begin
        // add, or subtract with b already negated during reduction
        unit_dbl = 1'b0;
        unit_acc = a_r;
        unit_add = b_r;
      end
      default: begin
        unit_dbl = 1'b1;
      end
    endcase
  end

  always_comb begin
    unit_t  = (unit_dbl ? {1'b0, unit_acc, 1'b0} : {2'b00, unit_acc}) + {2'b00, unit_add};
    unit_m1 = {2'b00, m_r};
    unit_m2 = {1'b0, m_r, 1'b0};
    if (unit_t >= unit_m2) begin
      unit_d = unit_t - unit_m2;
    end else if (unit_t >= unit_m1) begin
      unit_d = unit_t - unit_m1;
    end else begin
      unit_d = unit_t;
    end
    unit_q = unit_d[30:0];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    func_nxt      = func_r;
    tgt_nxt       = tgt_r;
    raw_nxt       = raw_r;
    opb_nxt       = opb_r;
    flip_nxt      = flip_r;
    sel_b_nxt     = sel_b_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    pacc_nxt      = pacc_r;
    psq_nxt       = psq_r;
    exp_nxt       = exp_r;
    val_nxt       = val_r;

    if (cfg_valid && cfg_ready) begin
      m_nxt = cfg_modulus;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      pma_pkg::ST_IDLE: begin
        if (in_valid) begin
          func_nxt = pma_pkg::func_t'(in_func);
          opb_nxt  = $unsigned(in_operand_b);
          if (m_r == 31'd0) begin
            // no modulus: every operation gives zero
            val_nxt   = 31'd0;
            state_nxt = pma_pkg::ST_OUT;
          end else begin
            raw_nxt   = ld_mag;
            flip_nxt  = ld_src[63] ^ (in_func == pma_pkg::FN_NEGATE);
            sel_b_nxt = 1'b0;
            acc_nxt   = 31'd0;
            cnt_nxt   = pma_pkg::RED_LAST;
            state_nxt = pma_pkg::ST_RED;
          end
        end
      end

      pma_pkg::ST_RED: begin
        acc_nxt = unit_q;
        raw_nxt = {raw_r[62:0], 1'b0};
        if (cnt_r == 6'd0) begin
          state_nxt = pma_pkg::ST_RFIX;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end

      pma_pkg::ST_RFIX: begin
        if (!sel_b_r) begin
          a_nxt     = fix_val;
          raw_nxt   = ld_mag;
          flip_nxt  = ld_src[63] ^ (func_r == pma_pkg::FN_SUB);
          sel_b_nxt = 1'b1;
          acc_nxt   = 31'd0;
          cnt_nxt   = pma_pkg::RED_LAST;
          state_nxt = pma_pkg::ST_RED;
        end else begin
          b_nxt     = fix_val;
          state_nxt = pma_pkg::ST_DISP;
        end
      end

      pma_pkg::ST_DISP: begin
        case (func_r)
          pma_pkg::FN_REDUCE: begin
            val_nxt   = b_r;
            state_nxt = pma_pkg::ST_OUT;
          end
          pma_pkg::FN_NEGATE: begin
            val_nxt   = a_r;
            state_nxt = pma_pkg::ST_OUT;
          end
          pma_pkg::FN_ADD, pma_pkg::FN_SUB: begin
            state_nxt = pma_pkg::ST_FIN;
          end
          pma_pkg::FN_MUL: begin
            x_nxt     = a_r;
            y_nxt     = b_r;
            tgt_nxt   = pma_pkg::TGT_RES;
            acc_nxt   = 31'd0;
            cnt_nxt   = pma_pkg::MUL_LAST;
            state_nxt = pma_pkg::ST_MUL;
          end
          pma_pkg::FN_DIV: begin
            pacc_nxt  = unit_one;
            psq_nxt   = b_r;
            exp_nxt   = m_less2[EXP_BITS-1:0];
            state_nxt = pma_pkg::ST_PSTEP;
          end
          pma_pkg::FN_POW: begin
            // negative exponent leaves the accumulator at one
            pacc_nxt  = unit_one;
            psq_nxt   = a_r;
            exp_nxt   = opb_r[63] ? '0 : opb_r[EXP_BITS-1:0];
            state_nxt = pma_pkg::ST_PSTEP;
          end
          pma_pkg::FN_INV: begin
            pacc_nxt  = unit_one;
            psq_nxt   = a_r;
            exp_nxt   = m_less2[EXP_BITS-1:0];
            state_nxt = pma_pkg::ST_PSTEP;
          end
          pma_pkg::FN_EQUAL: begin
            val_nxt   = {30'd0, (a_r == b_r)};
            state_nxt = pma_pkg::ST_OUT;
          end
          default: begin
            val_nxt   = 31'd0;
            state_nxt = pma_pkg::ST_OUT;
          end
        endcase
      end

      pma_pkg::ST_FIN: begin
        val_nxt   = unit_q;
        state_nxt = pma_pkg::ST_OUT;
      end

      pma_pkg::ST_PSTEP: begin
        // stop once no exponent bits remain; later squares cannot change the result
        if (exp_r == '0) begin
          state_nxt = pma_pkg::ST_PEND;
        end else begin
          if (exp_r[0]) begin
            x_nxt   = pacc_r;
            tgt_nxt = pma_pkg::TGT_PACC;
          end else begin
            x_nxt   = psq_r;
            tgt_nxt = pma_pkg::TGT_PSQ;
          end
          y_nxt     = psq_r;
          acc_nxt   = 31'd0;
          cnt_nxt   = pma_pkg::MUL_LAST;
          state_nxt = pma_pkg::ST_MUL;
        end
      end

      pma_pkg::ST_MUL: begin
        acc_nxt = unit_q;
        y_nxt   = {y_r[29:0], 1'b0};
        if (cnt_r == 6'd0) begin
          state_nxt = pma_pkg::ST_MEND;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end

      pma_pkg::ST_MEND: begin
        case (tgt_r)
          pma_pkg::TGT_PACC: begin
            pacc_nxt   = acc_r;
            exp_nxt[0] = 1'b0;
            state_nxt  = pma_pkg::ST_PSTEP;
          end
          pma_pkg::TGT_PSQ: begin
            psq_nxt   = acc_r;
            exp_nxt   = exp_r >> 1;
            state_nxt = pma_pkg::ST_PSTEP;
          end
          default: begin
            val_nxt   = acc_r;
            state_nxt = pma_pkg::ST_OUT;
          end
        endcase
      end

      pma_pkg::ST_PEND: begin
        case (func_r)
          pma_pkg::FN_DIV: begin
            if (b_r == 31'd0) begin
              // division by zero
              val_nxt   = 31'd0;
              state_nxt = pma_pkg::ST_OUT;
            end else begin
              x_nxt     = a_r;
              y_nxt     = pacc_r;
              tgt_nxt   = pma_pkg::TGT_RES;
              acc_nxt   = 31'd0;
              cnt_nxt   = pma_pkg::MUL_LAST;
              state_nxt = pma_pkg::ST_MUL;
            end
          end
          pma_pkg::FN_INV: begin
            // inverse of zero is zero
            val_nxt   = (a_r == 31'd0) ? 31'd0 : pacc_r;
            state_nxt = pma_pkg::ST_OUT;
          end
          default: begin
            val_nxt   = pacc_r;
            state_nxt = pma_pkg::ST_OUT;
          end
        endcase
      end

      pma_pkg::ST_OUT: begin
        // load the output register once it is empty or being emptied
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          res_nxt       = val_r;
          state_nxt     = pma_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pma_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pma_pkg::ST_IDLE;
      m_r         <= pma_pkg::MODULUS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      m_r         <= m_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    func_r  <= func_nxt;
    tgt_r   <= tgt_nxt;
    raw_r   <= raw_nxt;
    opb_r   <= opb_nxt;
    flip_r  <= flip_nxt;
    sel_b_r <= sel_b_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    cnt_r   <= cnt_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    pacc_r  <= pacc_nxt;
    psq_r   <= psq_nxt;
    exp_r   <= exp_nxt;
    val_r   <= val_nxt;
  end

  // checks
  `PMA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "idle after accept")
  `PMA_ASSERT_NOW(a_result_reduced, out_valid && m_r > 31'd1, out_result_value < m_r, "result >= M")
  `PMA_ASSERT_NOW(a_product_reduced, state_r == pma_pkg::ST_MEND, acc_r < m_r, "product >= M")

endmodule

### dv/tb.sv
module tb;

  // exponent width used by the block, and the mask it implies
  localparam int EXP_BITS = 63;
  localparam logic [63:0] EXP_MASK = (64'd1 << EXP_BITS) - 64'd1;
  // receiver hold-off length and the overall run limit, in cycles
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  // one accepted word together with the residue it must produce
  typedef struct {
    logic [3:0]  func;
    logic [63:0] a;
    logic [63:0] b;
    logic [30:0] value;
  } alu_case_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_func = '0;
  logic [63:0] in_operand_a = '0;
  logic [63:0] in_operand_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [30:0] out_result_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] cfg_modulus = '0;

  // predictor copy of the modulus register, starts at its reset value
  logic [30:0] modulus_model = pma_pkg::MODULUS_RESET;
  // residues still owed by the block, oldest first
  alu_case_t   residues_due[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  // steady: no idling on either side; hold_request: start a receiver hold-off
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;
  // the sender currently has in_valid high
  bit          offering = 1'b0;

  prime_modular_alu #(
    .EXP_BITS(EXP_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_modulus      (cfg_modulus)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // residue predictor
  // ---------------------------------------------------------------------

  // signed 64-bit operand into 0..m-1, a negative multiple of m gives 0
  function automatic longint unsigned to_residue(logic [63:0] raw, longint unsigned m);
    longint unsigned mag;
    if (!raw[63]) return raw % m;
    mag = (64'd0 - raw) % m;
    return (mag != 0) ? m - mag : 64'd0;
  endfunction

  // operands stay below 2^31 so the product fits in 64 bits
  function automatic longint unsigned prod_mod(longint unsigned x, longint unsigned y,
                                               longint unsigned m);
    return (x * y) % m;
  endfunction

  // square-and-multiply over the low exponent bits
  function automatic longint unsigned power_mod(longint unsigned base, logic [63:0] e,
                                                longint unsigned m);
    longint unsigned acc;
    longint unsigned sq;
    acc = 64'd1 % m;
    sq = base;
    for (int i = 0; i < EXP_BITS; i++) begin
      if (e[i]) acc = prod_mod(acc, sq, m);
      sq = prod_mod(sq, sq, m);
    end
    return acc;
  endfunction

  // a^(m-2), with zero mapped to zero
  function automatic longint unsigned fermat_inverse(longint unsigned x, longint unsigned m);
    if (x == 0) return 64'd0;
    return power_mod(x, m - 64'd2, m);
  endfunction

  function automatic logic [30:0] predict_residue(logic [3:0] f, logic [63:0] a_raw,
                                                  logic [63:0] b_raw, logic [30:0] mod);
    longint unsigned m;
    longint unsigned ra;
    longint unsigned rb;
    longint unsigned r;
    m = mod;
    // a zero modulus answers 0 for everything
    if (m == 0) return '0;
    ra = to_residue(a_raw, m);
    rb = to_residue(b_raw, m);
    r = 0;
    case (f)
      pma_pkg::FN_REDUCE: r = rb;
      pma_pkg::FN_NEGATE: r = (ra != 0) ? m - ra : 64'd0;
      pma_pkg::FN_ADD:    r = (ra + rb) % m;
      pma_pkg::FN_SUB:    r = (ra + (m - rb)) % m;
      pma_pkg::FN_MUL:    r = prod_mod(ra, rb, m);
      pma_pkg::FN_DIV:    r = prod_mod(ra, fermat_inverse(rb, m), m);
      // negative exponent gives 1 mod m
      pma_pkg::FN_POW:    r = b_raw[63] ? 64'd1 % m : power_mod(ra, b_raw & EXP_MASK, m);
      pma_pkg::FN_INV:    r = fermat_inverse(ra, m);
      pma_pkg::FN_EQUAL:  r = (ra == rb) ? 64'd1 : 64'd0;
      default:            r = 0;
    endcase
    return r[30:0];
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // operand mix: wide random, small signed, near multiples of m, extremes, residues
  function automatic logic [63:0] random_operand(longint unsigned m);
    int unsigned sel;
    logic [63:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      v = {$urandom, $urandom};
    end else if (sel < 55) begin
      v = 64'($urandom_range(0, 40)) - 64'd20;
    end else if (sel < 75) begin
      v = 64'($urandom) * m + 64'($urandom_range(0, 2)) - 64'd1;
      if ($urandom_range(0, 1) == 1) v = 64'd0 - v;
    end else if (sel < 80) begin
      case ($urandom_range(0, 3))
        0:       v = 64'h8000_0000_0000_0000;
        1:       v = 64'h7fff_ffff_ffff_ffff;
        2:       v = '0;
        default: v = '1;
      endcase
    end else begin
      v = {$urandom, $urandom} % m;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input alu_case_t c,
                                 input logic [30:0] got);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch: %s func=%0d a=%h b=%h expected=%0d got=%0d",
               what, c.func, c.a, c.b, c.value, got);
  endtask

  // offer one word, hold it until accepted, then record its residue
  task automatic send_word(input logic [3:0] f, input logic [63:0] a, input logic [63:0] b);
    alu_case_t c;
    if (!steady && $urandom_range(0, 99) < 36) begin
      if (offering) in_valid <= 1'b0;
      offering = 1'b0;
      // mostly short gaps, now and then a long one
      if ($urandom_range(0, 15) == 0) begin
        repeat ($urandom_range(20, 200)) @(posedge clk);
      end else begin
        do @(posedge clk); while ($urandom_range(0, 99) < 36);
      end
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_operand_a <= a;
    in_operand_b <= b;
    offering = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    c.func  = f;
    c.a     = a;
    c.b     = b;
    c.value = predict_residue(f, a, b, modulus_model);
    residues_due.push_back(c);
  endtask

  // stop offering and wait until every owed residue has come back
  task automatic drain_results();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
    while (residues_due.size() != 0) @(posedge clk);
  endtask

  // modulus write, only while drained and not offering
  task automatic set_modulus(input logic [30:0] value);
    cfg_valid   <= 1'b1;
    cfg_modulus <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    modulus_model = value;
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // reset modulus: operand extremes, every operation and the special cases
  task automatic test_directed_reset_modulus();
    logic [63:0] m;
    m = pma_pkg::MODULUS_RESET;
    send_word(pma_pkg::FN_REDUCE, '0, 64'h8000_0000_0000_0000);
    send_word(pma_pkg::FN_REDUCE, '0, 64'h7fff_ffff_ffff_ffff);
    // negative multiple of m reduces to zero
    send_word(pma_pkg::FN_REDUCE, '0, 64'd0 - 64'd3 * m);
    send_word(pma_pkg::FN_NEGATE, '0, '0);
    send_word(pma_pkg::FN_NEGATE, '1, '1);
    send_word(pma_pkg::FN_ADD, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
    send_word(pma_pkg::FN_SUB, '0, 64'd1);
    send_word(pma_pkg::FN_MUL, m - 64'd1, m - 64'd1);
    // division by zero gives zero
    send_word(pma_pkg::FN_DIV, 64'd5, '0);
    send_word(pma_pkg::FN_DIV, 64'd1, 64'd3);
    // negative exponent, zero exponent, widest exponent
    send_word(pma_pkg::FN_POW, 64'd3, 64'd0 - 64'd5);
    send_word(pma_pkg::FN_POW, 64'd7, '0);
    send_word(pma_pkg::FN_POW, 64'd2, 64'h7fff_ffff_ffff_ffff);
    // inverse of zero
    send_word(pma_pkg::FN_INV, '0, '0);
    send_word(pma_pkg::FN_INV, 64'd2, '1);
    send_word(pma_pkg::FN_EQUAL, 64'd5, 64'd5 + m);
    send_word(pma_pkg::FN_EQUAL, 64'd5, 64'd6);
    // unknown operation codes
    send_word(4'(pma_pkg::FN_EQUAL) + 4'd1, '1, '1);
    send_word(4'hf, '1, '1);
  endtask

  // largest and smallest moduli, modulus one, modulus zero, a non-prime modulus
  task automatic test_modulus_extremes();
    drain_results();
    set_modulus(31'h7fff_ffff);
    send_word(pma_pkg::FN_MUL, 64'd0 - 64'd2, 64'h7fff_ffff_ffff_ffff);
    send_word(pma_pkg::FN_INV, 64'd0 - 64'd2, '0);
    drain_results();
    set_modulus(31'd2);
    send_word(pma_pkg::FN_POW, 64'd3, 64'h7fff_ffff_ffff_ffff);
    send_word(pma_pkg::FN_SUB, 64'd1, 64'd0 - 64'd1);
    drain_results();
    // everything collapses to zero, equal is always 1
    set_modulus(31'd1);
    send_word(pma_pkg::FN_EQUAL, 64'd3, 64'd4);
    send_word(pma_pkg::FN_POW, 64'd3, 64'd0 - 64'd1);
    drain_results();
    set_modulus(31'd0);
    send_word(pma_pkg::FN_ADD, 64'd3, 64'd4);
    send_word(pma_pkg::FN_EQUAL, 64'd3, 64'd3);
    drain_results();
    // not prime: the power is still computed
    set_modulus(31'd1000000);
    send_word(pma_pkg::FN_INV, 64'd3, '0);
  endtask

  // random words under one modulus setting
  task automatic test_random_traffic(input logic [30:0] mod, input int count,
                                     input bit no_idle);
    logic [3:0]  f;
    logic [63:0] a;
    logic [63:0] b;
    int unsigned pick;
    drain_results();
    set_modulus(mod);
    steady = no_idle;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      // power, inverse and divide are slow, keep them to a minority
      if (pick < 14)      f = pma_pkg::FN_REDUCE;
      else if (pick < 26) f = pma_pkg::FN_NEGATE;
      else if (pick < 40) f = pma_pkg::FN_ADD;
      else if (pick < 54) f = pma_pkg::FN_SUB;
      else if (pick < 68) f = pma_pkg::FN_MUL;
      else if (pick < 78) f = pma_pkg::FN_EQUAL;
      else if (pick < 84) f = pma_pkg::FN_DIV;
      else if (pick < 90) f = pma_pkg::FN_POW;
      else if (pick < 95) f = pma_pkg::FN_INV;
      else                f = 4'(pma_pkg::FN_EQUAL) + 4'($urandom_range(1, 7));
      a = random_operand(mod);
      b = random_operand(mod);
      if (f == pma_pkg::FN_POW) begin
        // mostly short exponents, some negative, a few full width
        pick = $urandom_range(0, 99);
        if (pick < 60)      b = 64'($urandom_range(0, 1023));
        else if (pick < 75) b = {1'b1, 31'($urandom), $urandom};
        else if (pick < 88) b = {1'b0, 31'($urandom), $urandom};
      end else if (f == pma_pkg::FN_EQUAL && $urandom_range(0, 1) == 1) begin
        // same residue through a different representative
        b = a + 64'($urandom_range(0, 3)) * 64'(mod);
      end
      send_word(f, a, b);
    end
    steady = 1'b0;
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_holdoff();
    drain_results();
    steady = 1'b1;
    hold_request = 1'b1;
    repeat (8)
      send_word(pma_pkg::FN_MUL, random_operand(modulus_model),
                random_operand(modulus_model));
    steady = 1'b0;
  endtask

  // sender pauses until nothing is owed, then carries on
  task automatic test_drain_pause();
    repeat (4)
      send_word(pma_pkg::FN_ADD, random_operand(modulus_model),
                random_operand(modulus_model));
    drain_results();
    repeat (4)
      send_word(pma_pkg::FN_SUB, random_operand(modulus_model),
                random_operand(modulus_model));
    drain_results();
  endtask

  // ---------------------------------------------------------------------
  // receiver: random stalls, calm stretches and a counted hold-off
  // ---------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 36);
      end
    end
  end

  // ---------------------------------------------------------------------
  // result checker: each accepted word against the oldest residue owed
  // ---------------------------------------------------------------------
  initial begin
    alu_case_t due;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (residues_due.size() == 0) begin
          due = '{default: '0};
          report_mismatch("result with nothing owed", due, out_result_value);
        end else begin
          due = residues_due.pop_front();
          if (out_result_value !== due.value)
            report_mismatch("wrong residue", due, out_result_value);
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_reset_modulus();
    test_modulus_extremes();
    // first random phase runs with no idling at all
    test_random_traffic(pma_pkg::MODULUS_RESET, 205, 1'b1);
    test_random_traffic(31'h7fff_ffff, 205, 1'b0);
    test_output_holdoff();
    test_random_traffic(31'd1000000007, 205, 1'b0);
    test_random_traffic(31'd2, 200, 1'b0);
    test_drain_pause();
    case ($urandom_range(0, 3))
      0:       test_random_traffic(31'd3, 200, 1'b0);
      1:       test_random_traffic(31'd7, 200, 1'b0);
      2:       test_random_traffic(31'd257, 200, 1'b0);
      default: test_random_traffic(31'd65521, 200, 1'b0);
    endcase
    // random wide modulus, prime or not
    test_random_traffic({1'b1, 30'($urandom)}, 180, 1'b0);
    drain_results();
    // catch any stray result after the last one owed
    repeat (300) @(posedge clk);
    if (residues_due.size() != 0)
      report_mismatch("result never arrived", residues_due[0], '0);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
